[rtl/core/tile_background_pixel_fetch_assert.svh]
// Assertion macros shared by the checker module of the pixel fetch block.
`ifndef TILE_BACKGROUND_PIXEL_FETCH_ASSERT_SVH
`define TILE_BACKGROUND_PIXEL_FETCH_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define TBPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is held.
`define TBPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TBPF_ASSERT_RESET(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tbpf_pkg.sv]
package tbpf_pkg;

  localparam int NAME_TABLE_BYTES = 1024;
  localparam int PATTERN_BYTES    = 8192;
  localparam int TILE_BYTES       = 32 * 30;
  localparam int PALETTE_ENTRIES  = 16;

  localparam int NT_AW   = $clog2(NAME_TABLE_BYTES);
  localparam int PAT_AW  = $clog2(PATTERN_BYTES);
  localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
  localparam int ADDR_W  = 13;
  localparam int DATA_W  = 32;
  localparam int COORD_W = 8;
  localparam int INDEX_W = 4;

  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_PALETTE = 2'd2,
    KIND_RENDER  = 2'd3
  } kind_t;

  // Word after the name table read.
  typedef struct packed {
    logic              render;
    logic              pal_we;
    logic [PAL_AW-1:0] pal_addr;
    logic [DATA_W-1:0] pal_data;
    logic [2:0]        row;
    logic [2:0]        col;
    logic [2:0]        ashift;
  } s1_t;

  // Word after the pattern read.
  typedef struct packed {
    logic              render;
    logic              pal_we;
    logic [PAL_AW-1:0] pal_addr;
    logic [DATA_W-1:0] pal_data;
    logic [2:0]        col;
    logic [1:0]        high;
  } s2_t;

endpackage

[rtl/core/tbpf_if.sv]
interface tbpf_in_if import tbpf_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [ADDR_W-1:0]  write_addr;
  logic [DATA_W-1:0]  write_data;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;

  modport source (output valid, kind, write_addr, write_data, pixel_x, pixel_y,
                  input ready);
  modport sink (input valid, kind, write_addr, write_data, pixel_x, pixel_y,
                output ready);
endinterface

interface tbpf_out_if import tbpf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  pixel_color;
  logic [INDEX_W-1:0] color_index;

  modport source (output valid, pixel_color, color_index, input ready);
  modport sink (input valid, pixel_color, color_index, output ready);
endinterface

[rtl/core/tile_background_pixel_fetch.sv]
// Channel   Dir  Handshake     Word
// in_ch     in   valid/ready   kind, write_addr, write_data, pixel_x, pixel_y
// out_ch    out  valid/ready   pixel_color, color_index
// cfg       in   cfg_we        cfg_data (pattern half select)
//
// One word is accepted per cycle while stage 1 can take it. For a rendered pixel the name
// table is read at the accepting edge, the pattern store as the word leaves stage 1 and
// the palette into the output register as the word leaves stage 2.
// Reset is synchronous and clears only the stage and output valid bits and the pattern half.
// When the output is held, words keep entering until a render waits in stage 2 and stage 1 is full.
module tile_background_pixel_fetch import tbpf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tbpf_in_if.sink    in_ch,
  tbpf_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_data
);

  logic [7:0]        name_mem_r [NAME_TABLE_BYTES];
  logic [7:0]        pat_mem_r  [PATTERN_BYTES];
  logic [DATA_W-1:0] pal_r      [PALETTE_ENTRIES];

  logic half_r;
  logic s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt, out_v_r, out_v_nxt;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  logic [7:0] s1_tile_r, s1_attr_r, s2_p0_r, s2_p1_r;
  logic [DATA_W-1:0]  out_color_r;
  logic [INDEX_W-1:0] out_index_r;

  logic out_adv, s2_adv, s2_free, s1_adv, s1_free, acc;
  logic [NT_AW-1:0]  cell_addr, attr_addr;
  logic [ADDR_W-1:0] pat_full0, pat_full1;
  logic [7:0]        attr_sh;
  logic [1:0]        low;
  logic [INDEX_W-1:0] idx, entry;

  assign out_adv = !out_v_r || out_ch.ready;
  assign s2_adv  = s2_v_r && (!s2_r.render || out_adv);
  assign s2_free = !s2_v_r || s2_adv;
  assign s1_adv  = s1_v_r && s2_free;
  assign s1_free = !s1_v_r || s1_adv;
  assign acc     = in_ch.valid && s1_free;

  assign in_ch.ready        = s1_free;
  assign out_ch.valid       = out_v_r;
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.color_index = out_index_r;

  assign cell_addr = {in_ch.pixel_y[7:3], in_ch.pixel_x[7:3]};
  assign attr_addr = NT_AW'(TILE_BYTES) + NT_AW'({in_ch.pixel_y[7:5], in_ch.pixel_x[7:5]});

  always_comb begin
    s1_nxt.render   = (in_ch.kind == KIND_RENDER);
    s1_nxt.pal_we   = (in_ch.kind == KIND_PALETTE);
    s1_nxt.pal_addr = in_ch.write_addr[PAL_AW-1:0];
    s1_nxt.pal_data = in_ch.write_data;
    s1_nxt.row      = in_ch.pixel_y[2:0];
    s1_nxt.col      = in_ch.pixel_x[2:0];
    s1_nxt.ashift   = {in_ch.pixel_y[4], in_ch.pixel_x[4], 1'b0};
  end

  assign pat_full0 = {half_r, s1_tile_r, 1'b0, s1_r.row};
  assign pat_full1 = {half_r, s1_tile_r, 1'b1, s1_r.row};
  assign attr_sh   = s1_attr_r >> s1_r.ashift;

  always_comb begin
    s2_nxt.render   = s1_r.render;
    s2_nxt.pal_we   = s1_r.pal_we;
    s2_nxt.pal_addr = s1_r.pal_addr;
    s2_nxt.pal_data = s1_r.pal_data;
    s2_nxt.col      = s1_r.col;
    s2_nxt.high     = attr_sh[1:0];
  end

  assign low   = {s2_p1_r[~s2_r.col], s2_p0_r[~s2_r.col]};
  assign idx   = {s2_r.high, low};
  assign entry = (low == 2'd0) ? '0 : idx;

  always_comb begin
    s1_v_nxt  = acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    s2_v_nxt  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_v_r);
    out_v_nxt = (s2_adv && s2_r.render) ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        half_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_ch.kind == KIND_NAME) begin
      name_mem_r[in_ch.write_addr[NT_AW-1:0]] <= in_ch.write_data[7:0];
    end
    if (acc) begin
      s1_r      <= s1_nxt;
      s1_tile_r <= name_mem_r[cell_addr];
      s1_attr_r <= name_mem_r[attr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_ch.kind == KIND_PATTERN) begin
      pat_mem_r[in_ch.write_addr[PAT_AW-1:0]] <= in_ch.write_data[7:0];
    end
    if (s1_adv) begin
      s2_r    <= s2_nxt;
      s2_p0_r <= pat_mem_r[pat_full0[PAT_AW-1:0]];
      s2_p1_r <= pat_mem_r[pat_full1[PAT_AW-1:0]];
    end
  end

  // Palette writes commit at the same stage where renders read the palette,
  // so each render sees exactly the writes that came before it.
  always_ff @(posedge clk) begin
    if (s2_adv && s2_r.pal_we) begin
      pal_r[s2_r.pal_addr] <= s2_r.pal_data;
    end
    if (s2_adv && s2_r.render) begin
      out_color_r <= pal_r[entry];
      out_index_r <= idx;
    end
  end

endmodule

[rtl/core/tbpf_checker.sv]
`include "tile_background_pixel_fetch_assert.svh"

module tbpf_checker import tbpf_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DATA_W-1:0]  out_color,
  input logic [INDEX_W-1:0] out_index
);

  `TBPF_ASSERT_RESET(a_reset_clears_out, !rst_n, !out_valid, "output valid after reset")

  `TBPF_ASSERT_NEXT(a_out_holds, out_valid && !out_ready,
    out_valid && $stable(out_color) && $stable(out_index), "held output word changed")

  `TBPF_ASSERT_NOW(a_ready_when_out_empty, !out_valid, in_ready,
    "input stalled while output register is empty")

  `TBPF_ASSERT_NOW(a_ready_when_out_taken, out_valid && out_ready, in_ready,
    "input stalled while output word is taken")

endmodule

bind tile_background_pixel_fetch tbpf_checker u_tbpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_color (out_ch.pixel_color),
  .out_index (out_ch.color_index)
);
